[rtl/hacfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacfc_pkg
// Shared types, character codes, status codes and the per-character
// CRC-16-CCITT and hex decode functions of the frame checker.
// ----------------------------------------------------------------------------
package hacfc_pkg;

  localparam int unsigned LEN_W = 6;

  localparam logic [7:0]  FRAME_OPEN  = 8'h7B;
  localparam logic [7:0]  FRAME_CLOSE = 8'h7D;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT  = 16'h0000;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_FRAME = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC   = 2'd2;
  localparam logic [1:0] STATUS_BAD_HEX   = 2'd3;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       valid;
    result_t    res;
  } frame_out_t;

  // one character through the msb-first crc, eight shift steps
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  ch);
    logic [15:0] c;
    c = crc_in ^ {ch, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // returns {ok, nibble}; a non-hex character decodes as nibble 0
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/hacfc_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacfc_frame
// Frame state: character position, running crc, held nibble, received crc
// and sticky error. Steps once per character and forms at most one result.
// ----------------------------------------------------------------------------
module hacfc_frame #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned POS_W       = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hacfc_pkg::LEN_W-1:0]   cfg_len,
  input  logic                          step,
  input  logic [7:0]                    ch,
  output hacfc_pkg::frame_out_t         fout
);
  import hacfc_pkg::*;

  localparam int unsigned EW = (POS_W > LEN_W) ? POS_W + 1 : LEN_W + 1;

  logic [LEN_W-1:0] payload_length;
  logic [POS_W-1:0] char_position;
  logic [15:0]      running_crc;
  logic [3:0]       high_nibble_hold;
  logic [15:0]      received_crc;
  logic [1:0]       error_code;

  logic [POS_W-1:0] char_position_next;
  logic [15:0]      running_crc_next;
  logic [3:0]       high_nibble_hold_next;
  logic [15:0]      received_crc_next;
  logic [1:0]       error_code_next;

  logic [EW-1:0]    len_ext;
  logic [EW-1:0]    n_eff;
  logic [POS_W-1:0] pay_end;
  logic [POS_W-1:0] close_pos;
  logic [4:0]       hex;
  logic [1:0]       status;

  // clamp the length into 1..MAX_PAYLOAD
  always_comb begin
    len_ext = EW'(payload_length);
    if (len_ext == '0) begin
      n_eff = EW'(1);
    end else if (len_ext > EW'(MAX_PAYLOAD)) begin
      n_eff = EW'(MAX_PAYLOAD);
    end else begin
      n_eff = len_ext;
    end
    pay_end   = POS_W'(n_eff << 1);
    close_pos = pay_end + POS_W'(5);
  end

  always_comb begin
    hex = hex_decode(ch);
    if (ch != FRAME_CLOSE || error_code == STATUS_BAD_FRAME) begin
      status = STATUS_BAD_FRAME;
    end else if (error_code != STATUS_OK) begin
      status = error_code;
    end else if ((running_crc ^ CRC_XOROUT) != received_crc) begin
      status = STATUS_BAD_CRC;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    char_position_next    = char_position;
    running_crc_next      = running_crc;
    high_nibble_hold_next = high_nibble_hold;
    received_crc_next     = received_crc;
    error_code_next       = error_code;
    fout.valid            = 1'b0;
    fout.res.kind         = KIND_BYTE;
    fout.res.data_byte    = 8'h00;
    fout.res.status       = STATUS_OK;
    fout.res.last         = 1'b0;

    if (char_position >= close_pos) begin
      fout.valid            = 1'b1;
      fout.res.kind         = KIND_STATUS;
      fout.res.status       = status;
      fout.res.last         = 1'b1;
      char_position_next    = '0;
      running_crc_next      = CRC_INIT;
      high_nibble_hold_next = 4'h0;
      received_crc_next     = 16'h0000;
      error_code_next       = STATUS_OK;
    end else begin
      char_position_next = char_position + POS_W'(1);
      if (char_position == '0) begin
        if (ch != FRAME_OPEN) begin
          error_code_next = STATUS_BAD_FRAME;
        end
      end else begin
        if (!hex[4] && error_code == STATUS_OK) begin
          error_code_next = STATUS_BAD_HEX;
        end
        if (char_position <= pay_end) begin
          running_crc_next = crc_update(running_crc, ch);
          if (char_position[0]) begin
            high_nibble_hold_next = hex[3:0];
          end else begin
            fout.valid         = 1'b1;
            fout.res.data_byte = {high_nibble_hold, hex[3:0]};
          end
        end else begin
          received_crc_next = {received_crc[11:0], hex[3:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      payload_length   <= rst ? LEN_RESET : cfg_len;
      char_position    <= '0;
      running_crc      <= CRC_INIT;
      high_nibble_hold <= 4'h0;
      received_crc     <= 16'h0000;
      error_code       <= STATUS_OK;
    end else if (step) begin
      char_position    <= char_position_next;
      running_crc      <= running_crc_next;
      high_nibble_hold <= high_nibble_hold_next;
      received_crc     <= received_crc_next;
      error_code       <= error_code_next;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    char_position <= close_pos)
    else $error("character position past the closing character");

  a_status_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && fout.valid && fout.res.last) |=> (char_position == '0))
    else $error("frame did not restart after its status");

  a_byte_on_even: assert property (@(posedge clk) disable iff (rst)
    (fout.valid && fout.res.kind == KIND_BYTE) |->
      (!char_position[0] && char_position != '0 && char_position <= pay_end))
    else $error("payload byte outside an even payload position");

  a_hex_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg_we && error_code == STATUS_BAD_HEX && !fout.res.last)
      |=> (error_code == STATUS_BAD_HEX))
    else $error("hex error dropped inside a frame");

endmodule

[rtl/hacfc_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacfc_out
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hacfc_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hacfc_pkg::result_t res_in,
  input  logic              stall,
  output logic              free,
  output logic              valid,
  output hacfc_pkg::result_t res_out
);
  import hacfc_pkg::*;

  // slot can take a new result if empty or draining this cycle
  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |-> !load)
    else $error("held result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (valid && res_out == $past(res_in)))
    else $error("loaded result not presented");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    valid |-> (res_out.last == (res_out.kind == KIND_STATUS)))
    else $error("last flag disagrees with result kind");

endmodule

[rtl/hex_ascii_crc_frame_checker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_ascii_crc_frame_checker_unit
// Hex-ASCII frame checker: decodes payload bytes, checks the CRC-16-CCITT
// over the payload characters and reports one status per frame.
// ----------------------------------------------------------------------------
// path: a character is held in the input register, then its result in the result register
// throughput: one character per cycle unless result_stall holds the result register full;
// the frame state steps once per cycle from the input register into the result register
// a character waits in the input register only while the result register is
// held full by result_stall
// reset: synchronous, payload_length returns to 32 and the frame restarts
module hex_ascii_crc_frame_checker_unit #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       result_kind,
  output logic [7:0] data_byte,
  output logic [1:0] frame_status,
  output logic       last_of_frame
);
  import hacfc_pkg::*;

  localparam int unsigned POS_W = $clog2(2 * MAX_PAYLOAD + 6);

  logic       char_valid;
  logic [7:0] char_hold;
  logic       out_free;
  logic       step;
  logic       cfg_we;
  frame_out_t fout;
  result_t    res_q;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign step      = char_valid && out_free;
  assign rx_stall  = char_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      char_valid <= 1'b1;
    end else if (step) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      char_hold <= rx_char;
    end
  end

  hacfc_frame #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .POS_W       (POS_W)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_len (cfg_data),
    .step    (step),
    .ch      (char_hold),
    .fout    (fout)
  );

  hacfc_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && fout.valid),
    .res_in  (fout.res),
    .stall   (result_stall),
    .free    (out_free),
    .valid   (result_valid),
    .res_out (res_q)
  );

  assign result_kind   = res_q.kind;
  assign data_byte     = res_q.data_byte;
  assign frame_status  = res_q.status;
  assign last_of_frame = res_q.last;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (char_valid && result_valid))
    else $error("input stalled with nothing waiting");

  a_char_kept: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !step) |=> (char_valid && $stable(char_hold)))
    else $error("waiting character lost");

  a_step_drains: assert property (@(posedge clk) disable iff (rst)
    (step && !(rx_valid && !rx_stall)) |=> !char_valid)
    else $error("character processed twice");

endmodule
